// ===== rtl/fse_pkg.sv =====
// ----------------------------------------------------------------------------
// Fibonacci search extremum package
// Shared constants, tables and the sequencer state type.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int MaxSteps = 32;
  localparam int FracBits = 16;
  localparam int FibLast = 45;
  localparam int CordicSteps = 28;

  localparam logic [5:0] CfgStepCount = 6'd0;
  localparam logic [5:0] CfgProbeOffset = 6'd1;

  localparam logic signed [63:0] InvTwoPiQ32 = 64'sd683565276;
  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic signed [63:0] CordicGainQ30 = 64'sd652032874;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PL_MUL,
    ST_PL_DIV,
    ST_PL_END,
    ST_G_PH,
    ST_G_Z,
    ST_G_CORDIC,
    ST_G_MUL,
    ST_G_END,
    ST_STEP,
    ST_PASS_END,
    ST_OUT
  } state_t;

  function automatic logic [31:0] fib(input logic [5:0] i);
    logic [31:0] t [0:45];
    t = '{32'd1, 32'd1, 32'd2, 32'd3, 32'd5, 32'd8, 32'd13, 32'd21, 32'd34, 32'd55,
          32'd89, 32'd144, 32'd233, 32'd377, 32'd610, 32'd987, 32'd1597, 32'd2584,
          32'd4181, 32'd6765, 32'd10946, 32'd17711, 32'd28657, 32'd46368,
          32'd75025, 32'd121393, 32'd196418, 32'd317811, 32'd514229, 32'd832040,
          32'd1346269, 32'd2178309, 32'd3524578, 32'd5702887, 32'd9227465,
          32'd14930352, 32'd24157817, 32'd39088169, 32'd63245986, 32'd102334155,
          32'd165580141, 32'd267914296, 32'd433494437, 32'd701408733,
          32'd1134903170, 32'd1836311903};
    if (i > 6'd45) begin
      return 32'd1;
    end
    return t[i];
  endfunction

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd843314857;
      5'd1: r = 30'd497837829;
      5'd2: r = 30'd263043837;
      5'd3: r = 30'd133525159;
      5'd4: r = 30'd67021687;
      5'd5: r = 30'd33543516;
      5'd6: r = 30'd16775851;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194283;
      5'd9: r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fibonacci_search_extremum_unit.sv =====
// ----------------------------------------------------------------------------
// Fibonacci search extremum unit
// Runs a minimum and a maximum Fibonacci search of g(x)=(x-2)cos(x).
// ----------------------------------------------------------------------------
// channel  ports                                 direction
// in       in_valid/in_ready, interval_low/high   transfer in
// out      out_valid/out_ready, points and values transfer out
// cfg      cfg_we, cfg_index, cfg_data            write only
//
// Each item runs a minimum pass and then a maximum pass, n being the step
// count limited to 32; a count below two ends each pass after its two
// initial probes. Each probe runs a restoring divide, a CORDIC rotation
// and a multiply and update on one shared datapath.
// Reset is synchronous, active low, and returns the state, step count, probe offset and pass flag to defaults.
// in_ready is low from transfer until the result is taken; a stalled
// result holds.
module fibonacci_search_extremum_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_interval_low,
  input  logic signed [31:0] in_interval_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_min_point,
  output logic signed [31:0] out_max_point,
  output logic signed [31:0] out_value_at_min,
  output logic signed [31:0] out_value_at_max,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam int FracBitsHi = fse_pkg::FracBits + 31;

  fse_pkg::state_t state_r, state_nxt;

  logic [5:0]  steps_r;
  logic [16:0] eps_r;
  logic signed [31:0] a_in_r, b_in_r;
  logic signed [31:0] lo_r, hi_r, lp_r, rp_r, lv_r, rv_r;
  logic [5:0]  ne_r, j_r;
  logic        maxp_r, short_r, side_r, init_r;
  // side_r: 0 = placing left probe, 1 = right
  logic signed [63:0] num_r;
  logic [63:0] rem_r, quo_r;
  logic [31:0] den_r;
  logic [6:0]  cnt_r;
  logic signed [63:0] cx_r, cy_r, z_r;
  logic        flip_r;
  logic signed [31:0] x_r, pt_r, val_r, minp_r, minv_r;
  logic signed [63:0] prod_r;

  // shared signals
  logic [5:0]  nlim;
  logic signed [63:0] eps_s;
  logic [5:0]  k_s, m_s;
  logic signed [63:0] e_s;
  logic [63:0] mag_num;
  logic [5:0]  bit_idx;
  logic [64:0] trial;
  logic signed [63:0] q_s, sum_s, dx, dy;
  logic [31:0] ph, ph2;
  logic        fl;
  logic [32:0] mag;
  logic signed [31:0] sat_sum, gval;
  logic signed [63:0] gsh;
  logic        keep_l;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return -32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    nlim = (steps_r > 6'(fse_pkg::MaxSteps)) ? 6'(fse_pkg::MaxSteps) : steps_r;
    eps_s = 64'(signed'({1'b0, eps_r}));
    // place parameters
    if (init_r) begin
      m_s = ne_r;
      k_s = side_r ? ne_r - 6'd1 : ne_r - 6'd2;
      e_s = ne_r[0] ? -eps_s : eps_s;
    end else begin
      m_s = ne_r - j_r + 6'd1;
      k_s = side_r ? ne_r - j_r : ne_r - j_r - 6'd1;
      e_s = m_s[0] ? -eps_s : eps_s;
    end
    if (!side_r) e_s = -e_s;
    mag_num = num_r[63] ? 64'(-num_r) : 64'(num_r);
    // bring in the next dividend bit, most significant first
    bit_idx = 6'd63 - cnt_r[5:0];
    trial = {1'b0, rem_r[62:0], mag_num[bit_idx]} - {33'd0, den_r};
    q_s = num_r[63] ? -signed'(quo_r) : signed'(quo_r);
    sum_s = 64'(lo_r) + q_s;
    sat_sum = sat32(sum_s);
    ph = prod_r[FracBitsHi:fse_pkg::FracBits];
    fl = (ph + 32'h40000000) >= 32'h80000000;
    ph2 = fl ? ph + 32'h80000000 : ph;
    mag = ph2[31] ? 33'h100000000 - 33'(ph2) : 33'(ph2);
    dx = cy_r >>> cnt_r[4:0];
    dy = cx_r >>> cnt_r[4:0];
    gsh = prod_r >>> 30;
    gval = sat32(gsh);
    keep_l = maxp_r ? (lv_r >= rv_r) : (lv_r <= rv_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fse_pkg::ST_IDLE:     if (in_valid) state_nxt = fse_pkg::ST_SETUP;
      fse_pkg::ST_SETUP:    state_nxt = fse_pkg::ST_PL_MUL;
      fse_pkg::ST_PL_MUL:   state_nxt = fse_pkg::ST_PL_DIV;
      fse_pkg::ST_PL_DIV:   if (cnt_r == 7'd63) state_nxt = fse_pkg::ST_PL_END;
      fse_pkg::ST_PL_END:   state_nxt = fse_pkg::ST_G_PH;
      fse_pkg::ST_G_PH:     state_nxt = fse_pkg::ST_G_Z;
      fse_pkg::ST_G_Z:      state_nxt = fse_pkg::ST_G_CORDIC;
      fse_pkg::ST_G_CORDIC:
        if (cnt_r == 7'(fse_pkg::CordicSteps - 1)) state_nxt = fse_pkg::ST_G_MUL;
      fse_pkg::ST_G_MUL:    state_nxt = fse_pkg::ST_G_END;
      fse_pkg::ST_G_END: begin
        if (init_r && !side_r) state_nxt = fse_pkg::ST_PL_MUL;
        else if (init_r && short_r) state_nxt = fse_pkg::ST_PASS_END;
        else state_nxt = fse_pkg::ST_STEP;
      end
      fse_pkg::ST_STEP:
        state_nxt = (j_r > ne_r - 6'd1) ? fse_pkg::ST_PASS_END : fse_pkg::ST_PL_MUL;
      fse_pkg::ST_PASS_END:
        state_nxt = maxp_r ? fse_pkg::ST_OUT : fse_pkg::ST_SETUP;
      fse_pkg::ST_OUT:      if (out_ready) state_nxt = fse_pkg::ST_IDLE;
      default:              state_nxt = fse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fse_pkg::ST_IDLE;
      steps_r <= 6'd20;
      eps_r   <= 17'd66;
      maxp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == fse_pkg::CfgStepCount) steps_r <= cfg_data[5:0];
      if (cfg_we && cfg_index == fse_pkg::CfgProbeOffset) eps_r <= cfg_data;
      if (state_r == fse_pkg::ST_IDLE) maxp_r <= 1'b0;
      if (state_r == fse_pkg::ST_PASS_END) maxp_r <= ~maxp_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fse_pkg::ST_IDLE: begin
        a_in_r <= in_interval_low;
        b_in_r <= in_interval_high;
      end
      fse_pkg::ST_SETUP: begin
        lo_r    <= a_in_r;
        hi_r    <= b_in_r;
        short_r <= nlim < 6'd2;
        ne_r    <= (nlim < 6'd2) ? 6'd2 : nlim;
        init_r  <= 1'b1;
        side_r  <= 1'b0;
        j_r     <= 6'd1;
      end
      fse_pkg::ST_PL_MUL: begin
        // one 32x33 product
        num_r <= signed'({32'd0, fse_pkg::fib(k_s)}) * (64'(hi_r) - 64'(lo_r)) + e_s;
        den_r <= fse_pkg::fib(m_s);
        rem_r <= '0;
        cnt_r <= '0;
      end
      fse_pkg::ST_PL_DIV: begin
        if (!trial[64]) begin
          rem_r <= trial[63:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], mag_num[bit_idx]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
      end
      fse_pkg::ST_PL_END: begin
        x_r    <= sat_sum;
        prod_r <= 64'(sat_sum) * fse_pkg::InvTwoPiQ32;
      end
      fse_pkg::ST_G_PH: begin
        flip_r <= fl;
        prod_r <= signed'(64'({31'd0, mag} * 64'(fse_pkg::HalfPiQ30)));
      end
      fse_pkg::ST_G_Z: begin
        z_r   <= prod_r >>> 30;
        cx_r  <= fse_pkg::CordicGainQ30;
        cy_r  <= '0;
        cnt_r <= '0;
      end
      fse_pkg::ST_G_CORDIC: begin
        if (!z_r[63]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          z_r  <= z_r - 64'(fse_pkg::atan_q30(cnt_r[4:0]));
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          z_r  <= z_r + 64'(fse_pkg::atan_q30(cnt_r[4:0]));
        end
        cnt_r <= cnt_r + 7'd1;
      end
      fse_pkg::ST_G_MUL: begin
        prod_r <= (64'(x_r) - (64'sd2 <<< fse_pkg::FracBits)) *
                  (flip_r ? -cx_r : cx_r);
      end
      fse_pkg::ST_G_END: begin
        if (init_r) begin
          if (!side_r) begin
            lp_r <= x_r;
            lv_r <= gval;
            pt_r <= x_r;
            val_r <= gval;
            side_r <= 1'b1;
          end else begin
            rp_r <= x_r;
            rv_r <= gval;
            init_r <= 1'b0;
          end
        end else if (!side_r) begin
          lp_r <= x_r;
          lv_r <= gval;
          j_r  <= j_r + 6'd1;
        end else begin
          rp_r <= x_r;
          rv_r <= gval;
          j_r  <= j_r + 6'd1;
        end
      end
      fse_pkg::ST_STEP: begin
        if (j_r <= ne_r - 6'd1) begin
          if (keep_l) begin
            hi_r <= rp_r;
            rp_r <= lp_r;
            rv_r <= lv_r;
            pt_r <= lp_r;
            val_r <= lv_r;
            side_r <= 1'b0;
          end else begin
            lo_r <= lp_r;
            lp_r <= rp_r;
            lv_r <= rv_r;
            pt_r <= rp_r;
            val_r <= rv_r;
            side_r <= 1'b1;
          end
        end
      end
      fse_pkg::ST_PASS_END: begin
        if (!maxp_r) begin
          minp_r <= pt_r;
          minv_r <= val_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == fse_pkg::ST_IDLE);
  assign out_valid = (state_r == fse_pkg::ST_OUT);
  assign out_min_point = minp_r;
  assign out_value_at_min = minv_r;
  assign out_max_point = pt_r;
  assign out_value_at_max = val_r;

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("ready and valid together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_point))
    else $error("result dropped");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !maxp_r)
    else $error("max pass flag still set at result");

endmodule
